[rtl/hkrd_pkg.sv]
// ----------------------------------------------------------------------------
// hkrd_pkg
// Shared types, command and status structs, and mod-26 helper functions for
// the 2x2 Hill cipher key recovery and decrypt block.
// ----------------------------------------------------------------------------
package hkrd_pkg;

  localparam int unsigned SymW  = 5;
  localparam int unsigned SumW  = 11;
  localparam int unsigned Lanes = 4;

  localparam logic [SymW-1:0] Modulus = 5'd26;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusSingular = 2'd1;
  localparam logic [1:0] StatusNoKeyInv = 2'd2;

  typedef enum logic [2:0] {
    OP_DETP = 3'd0,
    OP_PINV = 3'd1,
    OP_KMAT = 3'd2,
    OP_DETK = 3'd3,
    OP_KINV = 3'd4,
    OP_DEC  = 3'd5
  } hkrd_op_e;

  typedef struct packed {
    hkrd_op_e op;
    logic     in_load;
    logic     mul_en;
    logic     red_en;
    logic     out_load;
  } hkrd_cmd_t;

  typedef struct packed {
    logic out_stall;
  } hkrd_sts_t;

  // Brings a 5-bit symbol into 0..25.
  function automatic logic [SymW-1:0] red26(input logic [SymW-1:0] x);
    red26 = (x >= Modulus) ? x - Modulus : x;
  endfunction

  // Additive inverse of a residue already in 0..25.
  function automatic logic [SymW-1:0] neg26(input logic [SymW-1:0] x);
    neg26 = (x == '0) ? '0 : Modulus - x;
  endfunction

  // Remainder by 26 of a sum up to 1250, through a reciprocal multiply.
  function automatic logic [SymW-1:0] mod26(input logic [SumW-1:0] v);
    logic [22:0]     prod;
    logic [5:0]      quot;
    logic [SumW-1:0] qm;
    prod = 23'(v) * 23'd2521;
    quot = prod[21:16];
    qm   = SumW'(quot) * SumW'(Modulus);
    mod26 = SymW'(v - qm);
  endfunction

  // Multiplicative inverse mod 26; zero when none exists.
  function automatic logic [SymW-1:0] inv26(input logic [SymW-1:0] x);
    case (x)
      5'd1:    inv26 = 5'd1;
      5'd3:    inv26 = 5'd9;
      5'd5:    inv26 = 5'd21;
      5'd7:    inv26 = 5'd15;
      5'd9:    inv26 = 5'd3;
      5'd11:   inv26 = 5'd19;
      5'd15:   inv26 = 5'd7;
      5'd17:   inv26 = 5'd23;
      5'd19:   inv26 = 5'd11;
      5'd21:   inv26 = 5'd5;
      5'd23:   inv26 = 5'd17;
      5'd25:   inv26 = 5'd25;
      default: inv26 = 5'd0;
    endcase
  endfunction

endpackage

[rtl/hkrd_ctrl.sv]
// ----------------------------------------------------------------------------
// hkrd_ctrl
// Sequencer that steps the shared multiply-reduce lanes through key recovery
// or decryption and hands the result to the output register.
// ----------------------------------------------------------------------------
module hkrd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 func_i,
  output logic                 in_ready_o,
  input  hkrd_pkg::hkrd_sts_t  sts_i,
  output hkrd_pkg::hkrd_cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_DETP_M = 14'b00000000000010,
    ST_DETP_R = 14'b00000000000100,
    ST_PINV_M = 14'b00000000001000,
    ST_PINV_R = 14'b00000000010000,
    ST_KMAT_M = 14'b00000000100000,
    ST_KMAT_R = 14'b00000001000000,
    ST_DETK_M = 14'b00000010000000,
    ST_DETK_R = 14'b00000100000000,
    ST_KINV_M = 14'b00001000000000,
    ST_KINV_R = 14'b00010000000000,
    ST_DEC_M  = 14'b00100000000000,
    ST_DEC_R  = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o.op         = hkrd_pkg::OP_DETP;
    cmd_o.in_load    = 1'b0;
    cmd_o.mul_en     = 1'b0;
    cmd_o.red_en     = 1'b0;
    cmd_o.out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d = func_i ? ST_DEC_M : ST_DETP_M;
        end
      end
      ST_DETP_M: begin
        cmd_o.op = hkrd_pkg::OP_DETP;
        cmd_o.mul_en = 1'b1;
        state_d = ST_DETP_R;
      end
      ST_DETP_R: begin
        cmd_o.red_en = 1'b1;
        state_d = ST_PINV_M;
      end
      ST_PINV_M: begin
        cmd_o.op = hkrd_pkg::OP_PINV;
        cmd_o.mul_en = 1'b1;
        state_d = ST_PINV_R;
      end
      ST_PINV_R: begin
        cmd_o.red_en = 1'b1;
        state_d = ST_KMAT_M;
      end
      ST_KMAT_M: begin
        cmd_o.op = hkrd_pkg::OP_KMAT;
        cmd_o.mul_en = 1'b1;
        state_d = ST_KMAT_R;
      end
      ST_KMAT_R: begin
        cmd_o.red_en = 1'b1;
        state_d = ST_DETK_M;
      end
      ST_DETK_M: begin
        cmd_o.op = hkrd_pkg::OP_DETK;
        cmd_o.mul_en = 1'b1;
        state_d = ST_DETK_R;
      end
      ST_DETK_R: begin
        cmd_o.red_en = 1'b1;
        state_d = ST_KINV_M;
      end
      ST_KINV_M: begin
        cmd_o.op = hkrd_pkg::OP_KINV;
        cmd_o.mul_en = 1'b1;
        state_d = ST_KINV_R;
      end
      ST_KINV_R: begin
        cmd_o.red_en = 1'b1;
        state_d = ST_DONE;
      end
      ST_DEC_M: begin
        cmd_o.op = hkrd_pkg::OP_DEC;
        cmd_o.mul_en = 1'b1;
        state_d = ST_DEC_R;
      end
      ST_DEC_R: begin
        cmd_o.red_en = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/hkrd_datapath.sv]
// ----------------------------------------------------------------------------
// hkrd_datapath
// Operand registers, four multiply-accumulate lanes with a mod-26 reduction
// stage, the stored inverse key and the output register.
// ----------------------------------------------------------------------------
module hkrd_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hkrd_pkg::hkrd_cmd_t  cmd_i,
  output hkrd_pkg::hkrd_sts_t  sts_o,
  input  logic                 func_i,
  input  logic [4:0]           p0_i,
  input  logic [4:0]           p1_i,
  input  logic [4:0]           p2_i,
  input  logic [4:0]           p3_i,
  input  logic [4:0]           c0_i,
  input  logic [4:0]           c1_i,
  input  logic [4:0]           c2_i,
  input  logic [4:0]           c3_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [4:0]           key00_o,
  output logic [4:0]           key01_o,
  output logic [4:0]           key10_o,
  output logic [4:0]           key11_o,
  output logic [4:0]           plain0_o,
  output logic [4:0]           plain1_o,
  output logic [1:0]           status_o
);

  localparam int unsigned W  = hkrd_pkg::SymW;
  localparam int unsigned SW = hkrd_pkg::SumW;
  localparam int unsigned L  = hkrd_pkg::Lanes;

  logic          func_q;
  logic [W-1:0]  pm_q [L];
  logic [W-1:0]  cm_q [L];
  logic [W-1:0]  kmat_q [L];
  logic [W-1:0]  res_q [L];
  logic [SW-1:0] sum_q [L];
  logic [W-1:0]  kinv_q [L];
  logic          kvalid_q;
  logic          psing_q;
  logic          kok_q;

  logic [W-1:0]  x0 [L];
  logic [W-1:0]  y0 [L];
  logic [W-1:0]  x1 [L];
  logic [W-1:0]  y1 [L];
  logic [W-1:0]  di;

  logic          out_valid_q;
  logic [W-1:0]  key_q [L];
  logic [W-1:0]  plain0_q, plain1_q;
  logic [1:0]    status_q;
  logic [1:0]    status_d;

  assign di = hkrd_pkg::inv26(res_q[0]);

  always_comb begin
    for (int i = 0; i < L; i++) begin
      x0[i] = '0;
      y0[i] = '0;
      x1[i] = '0;
      y1[i] = '0;
    end
    case (cmd_i.op)
      hkrd_pkg::OP_DETP: begin
        x0[0] = pm_q[0];
        y0[0] = pm_q[3];
        x1[0] = hkrd_pkg::neg26(pm_q[1]);
        y1[0] = pm_q[2];
      end
      hkrd_pkg::OP_PINV: begin
        x0[0] = pm_q[3];
        x0[1] = hkrd_pkg::neg26(pm_q[1]);
        x0[2] = hkrd_pkg::neg26(pm_q[2]);
        x0[3] = pm_q[0];
        for (int i = 0; i < L; i++) y0[i] = di;
      end
      hkrd_pkg::OP_KMAT: begin
        x0[0] = cm_q[0]; y0[0] = res_q[0]; x1[0] = cm_q[1]; y1[0] = res_q[2];
        x0[1] = cm_q[0]; y0[1] = res_q[1]; x1[1] = cm_q[1]; y1[1] = res_q[3];
        x0[2] = cm_q[2]; y0[2] = res_q[0]; x1[2] = cm_q[3]; y1[2] = res_q[2];
        x0[3] = cm_q[2]; y0[3] = res_q[1]; x1[3] = cm_q[3]; y1[3] = res_q[3];
      end
      hkrd_pkg::OP_DETK: begin
        x0[0] = res_q[0];
        y0[0] = res_q[3];
        x1[0] = hkrd_pkg::neg26(res_q[1]);
        y1[0] = res_q[2];
      end
      hkrd_pkg::OP_KINV: begin
        x0[0] = kmat_q[3];
        x0[1] = hkrd_pkg::neg26(kmat_q[1]);
        x0[2] = hkrd_pkg::neg26(kmat_q[2]);
        x0[3] = kmat_q[0];
        for (int i = 0; i < L; i++) y0[i] = di;
      end
      hkrd_pkg::OP_DEC: begin
        x0[0] = kinv_q[0]; y0[0] = cm_q[0]; x1[0] = kinv_q[1]; y1[0] = cm_q[1];
        x0[1] = kinv_q[2]; y0[1] = cm_q[0]; x1[1] = kinv_q[3]; y1[1] = cm_q[1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      func_q   <= func_i;
      pm_q[0]  <= hkrd_pkg::red26(p0_i);
      pm_q[1]  <= hkrd_pkg::red26(p1_i);
      pm_q[2]  <= hkrd_pkg::red26(p2_i);
      pm_q[3]  <= hkrd_pkg::red26(p3_i);
      cm_q[0]  <= hkrd_pkg::red26(c0_i);
      cm_q[1]  <= hkrd_pkg::red26(c1_i);
      cm_q[2]  <= hkrd_pkg::red26(c2_i);
      cm_q[3]  <= hkrd_pkg::red26(c3_i);
    end
    if (cmd_i.mul_en) begin
      for (int i = 0; i < L; i++) begin
        sum_q[i] <= SW'(x0[i]) * SW'(y0[i]) + SW'(x1[i]) * SW'(y1[i]);
      end
    end
    if (cmd_i.red_en) begin
      for (int i = 0; i < L; i++) begin
        res_q[i] <= hkrd_pkg::mod26(sum_q[i]);
      end
    end
    if (cmd_i.mul_en && (cmd_i.op == hkrd_pkg::OP_PINV)) begin
      psing_q <= (di == '0);
    end
    if (cmd_i.mul_en && (cmd_i.op == hkrd_pkg::OP_DETK)) begin
      for (int i = 0; i < L; i++) kmat_q[i] <= res_q[i];
    end
    if (cmd_i.mul_en && (cmd_i.op == hkrd_pkg::OP_KINV)) begin
      kok_q <= (di != '0);
    end
  end

  always_comb begin
    if (func_q) begin
      status_d = kvalid_q ? hkrd_pkg::StatusOk : hkrd_pkg::StatusNoKeyInv;
    end else if (psing_q) begin
      status_d = hkrd_pkg::StatusSingular;
    end else if (!kok_q) begin
      status_d = hkrd_pkg::StatusNoKeyInv;
    end else begin
      status_d = hkrd_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kvalid_q <= 1'b0;
      for (int i = 0; i < L; i++) kinv_q[i] <= '0;
    end else if (cmd_i.out_load && !func_q) begin
      kvalid_q <= kok_q;
      for (int i = 0; i < L; i++) kinv_q[i] <= res_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int i = 0; i < L; i++) key_q[i] <= func_q ? '0 : kmat_q[i];
      plain0_q <= func_q ? res_q[0] : '0;
      plain1_q <= func_q ? res_q[1] : '0;
      status_q <= status_d;
    end
  end

  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign key00_o     = key_q[0];
  assign key01_o     = key_q[1];
  assign key10_o     = key_q[2];
  assign key11_o     = key_q[3];
  assign plain0_o    = plain0_q;
  assign plain1_o    = plain1_q;
  assign status_o    = status_q;

endmodule

[rtl/hill_key_recovery_and_decrypt.sv]
// ----------------------------------------------------------------------------
// hill_key_recovery_and_decrypt
// 2x2 Hill cipher over mod 26: key recovery from a known pair and decryption
// with the stored inverse key.
// ----------------------------------------------------------------------------
// The input channel carries one transaction per item: func_i selects key
// recovery (0) from p0..p3 and c0..c3, or decryption (1) of the pair c0, c1.
// The output channel returns one transaction per item with the key, the
// plaintext pair and a status code.
// A recovery item is stepped through determinant and inverse steps for the
// plaintext, a product step that forms the key, and determinant and inverse
// steps for the key; a decrypt item takes one product step. A sequencer steps
// one bank of four multiply-add lanes, each followed by a mod-26 reduction
// stage, through these steps, each a multiply state then a reduce state, and
// then loads the output register, after which a new item can be accepted.
// Items are handled one at a time; in_ready_o is high whenever no item is in
// work, including while a finished result waits in the output register.
// If the receiver stalls, the next item's result is held back until the
// pending transaction is taken, and no new item is accepted meanwhile.
// Reset clears the stored inverse key to zeros and marks it not invertible,
// so a decrypt before any recovery returns zeros with status 2.
// ----------------------------------------------------------------------------
module hill_key_recovery_and_decrypt (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [4:0] p0_i,
  input  logic [4:0] p1_i,
  input  logic [4:0] p2_i,
  input  logic [4:0] p3_i,
  input  logic [4:0] c0_i,
  input  logic [4:0] c1_i,
  input  logic [4:0] c2_i,
  input  logic [4:0] c3_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] key00_o,
  output logic [4:0] key01_o,
  output logic [4:0] key10_o,
  output logic [4:0] key11_o,
  output logic [4:0] plain0_o,
  output logic [4:0] plain1_o,
  output logic [1:0] status_o
);

  hkrd_pkg::hkrd_cmd_t cmd;
  hkrd_pkg::hkrd_sts_t sts;

  hkrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hkrd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (func_i),
    .p0_i        (p0_i),
    .p1_i        (p1_i),
    .p2_i        (p2_i),
    .p3_i        (p3_i),
    .c0_i        (c0_i),
    .c1_i        (c1_i),
    .c2_i        (c2_i),
    .c3_i        (c3_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .key00_o     (key00_o),
    .key01_o     (key01_o),
    .key10_o     (key10_o),
    .key11_o     (key11_o),
    .plain0_o    (plain0_o),
    .plain1_o    (plain1_o),
    .status_o    (status_o)
  );

endmodule

[rtl/hkrd_checker.sv]
// ----------------------------------------------------------------------------
// hkrd_checker
// Port-level checks on the result and input channels of the Hill cipher block.
// ----------------------------------------------------------------------------
module hkrd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [4:0] key00_o,
  input logic [4:0] key01_o,
  input logic [4:0] key10_o,
  input logic [4:0] key11_o,
  input logic [4:0] plain0_o,
  input logic [4:0] plain1_o,
  input logic [1:0] status_o
);

  logic key_nz;
  assign key_nz = (key00_o != 5'd0) || (key01_o != 5'd0) ||
                  (key10_o != 5'd0) || (key11_o != 5'd0);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(key00_o) && $stable(plain0_o) && $stable(plain1_o))
    else $error("result transaction changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3 && key00_o < 5'd26 && key01_o < 5'd26 &&
      key10_o < 5'd26 && key11_o < 5'd26 && plain0_o < 5'd26 && plain1_o < 5'd26)
    else $error("result field out of range");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_nz |-> plain0_o == 5'd0 && plain1_o == 5'd0)
    else $error("key and plaintext both nonzero");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == 2'd1 |-> !key_nz && plain0_o == 5'd0 &&
      plain1_o == 5'd0)
    else $error("singular plaintext gave nonzero fields");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while busy");

endmodule

bind hill_key_recovery_and_decrypt hkrd_checker u_hkrd_checker (.*);

[bench/tb_hill_key_recovery_and_decrypt.sv]
// ----------------------------------------------------------------------------
// tb_hill_key_recovery_and_decrypt
// Self-checking bench for the 2x2 mod-26 Hill cipher key recovery and decrypt
// block. A behavioral predictor tracks the stored inverse key and computes the
// expected key, plaintext pair and status for every accepted input
// transaction. Output transactions are checked in order against those
// expectations. Directed corner cases come first, then random key sessions
// and noise, idling at random on both channels but for one steady stream.
// ----------------------------------------------------------------------------
module tb_hill_key_recovery_and_decrypt;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SymMod = 26;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles = 20;
  localparam logic FuncRecover = 1'b0;
  localparam logic FuncDecrypt = 1'b1;

  typedef logic [3:0][4:0] mat_t;

  typedef struct packed {
    logic func;
    mat_t p;
    mat_t c;
  } hill_item_t;

  typedef struct packed {
    mat_t       key;
    logic [4:0] plain0;
    logic [4:0] plain1;
    logic [1:0] status;
  } hill_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       func_i;
  logic [4:0] p0_i, p1_i, p2_i, p3_i;
  logic [4:0] c0_i, c1_i, c2_i, c3_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [4:0] key00_o, key01_o, key10_o, key11_o;
  logic [4:0] plain0_o, plain1_o;
  logic [1:0] status_o;

  mat_t         inv_key;
  logic         key_ok;
  hill_result_t expected_results[$];
  hill_result_t oldest_result;
  hill_item_t   accepted_item;
  int           errors;
  int           items_sent;
  int           quiet_cycles;
  bit           idle_en;

  hill_key_recovery_and_decrypt i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .p0_i       (p0_i),
    .p1_i       (p1_i),
    .p2_i       (p2_i),
    .p3_i       (p3_i),
    .c0_i       (c0_i),
    .c1_i       (c1_i),
    .c2_i       (c2_i),
    .c3_i       (c3_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .key00_o    (key00_o),
    .key01_o    (key01_o),
    .key10_o    (key10_o),
    .key11_o    (key11_o),
    .plain0_o   (plain0_o),
    .plain1_o   (plain1_o),
    .status_o   (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic mat_t mat(input int a, input int b, input int c, input int d);
    mat_t m;
    m[0] = 5'(a);
    m[1] = 5'(b);
    m[2] = 5'(c);
    m[3] = 5'(d);
    return m;
  endfunction

  function automatic int recip_mod26(input int x);
    for (int i = 1; i < SymMod; i++) begin
      if ((x * i) % SymMod == 1) return i;
    end
    return 0;
  endfunction

  // Returns 0 and a zero matrix when the determinant has no inverse mod 26.
  function automatic bit invert_mod26(input mat_t m, output mat_t r);
    int a, b, c, d, det, di;
    a = int'(m[0]) % SymMod;
    b = int'(m[1]) % SymMod;
    c = int'(m[2]) % SymMod;
    d = int'(m[3]) % SymMod;
    det = (a * d + SymMod * SymMod - b * c) % SymMod;
    di = recip_mod26(det);
    r = '0;
    if (di == 0) return 1'b0;
    r[0] = 5'((d * di) % SymMod);
    r[1] = 5'((((SymMod - b) % SymMod) * di) % SymMod);
    r[2] = 5'((((SymMod - c) % SymMod) * di) % SymMod);
    r[3] = 5'((a * di) % SymMod);
    return 1'b1;
  endfunction

  function automatic mat_t mul_mod26(input mat_t x, input mat_t y);
    mat_t r;
    r[0] = 5'((int'(x[0]) * int'(y[0]) + int'(x[1]) * int'(y[2])) % SymMod);
    r[1] = 5'((int'(x[0]) * int'(y[1]) + int'(x[1]) * int'(y[3])) % SymMod);
    r[2] = 5'((int'(x[2]) * int'(y[0]) + int'(x[3]) * int'(y[2])) % SymMod);
    r[3] = 5'((int'(x[2]) * int'(y[1]) + int'(x[3]) * int'(y[3])) % SymMod);
    return r;
  endfunction

  // Computes the result of one transaction and updates the stored inverse key.
  function automatic hill_result_t compute_key_and_plain(input hill_item_t it);
    hill_result_t r;
    mat_t         p_inv;
    mat_t         k_inv;
    r = '0;
    if (it.func == FuncRecover) begin
      if (!invert_mod26(it.p, p_inv)) begin
        r.status = hkrd_pkg::StatusSingular;
        inv_key = '0;
        key_ok = 1'b0;
      end else begin
        r.key = mul_mod26(it.c, p_inv);
        key_ok = invert_mod26(r.key, k_inv);
        inv_key = k_inv;
        if (!key_ok) r.status = hkrd_pkg::StatusNoKeyInv;
      end
    end else begin
      r.plain0 = 5'((int'(inv_key[0]) * int'(it.c[0]) + int'(inv_key[1]) * int'(it.c[1]))
                    % SymMod);
      r.plain1 = 5'((int'(inv_key[2]) * int'(it.c[0]) + int'(inv_key[3]) * int'(it.c[1]))
                    % SymMod);
      if (!key_ok) r.status = hkrd_pkg::StatusNoKeyInv;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("output transaction with no expected result pending");
          errors++;
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("key00", oldest_result.key[0], key00_o);
          check_field("key01", oldest_result.key[1], key01_o);
          check_field("key10", oldest_result.key[2], key10_o);
          check_field("key11", oldest_result.key[3], key11_o);
          check_field("plain0", oldest_result.plain0, plain0_o);
          check_field("plain1", oldest_result.plain1, plain1_o);
          check_field("status", oldest_result.status, status_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        accepted_item.func = func_i;
        accepted_item.p = {p3_i, p2_i, p1_i, p0_i};
        accepted_item.c = {c3_i, c2_i, c1_i, c0_i};
        expected_results.push_back(compute_key_and_plain(accepted_item));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= !idle_en || ($urandom_range(99) >= 14);
  end

  task automatic send_item(input logic f, input mat_t p, input mat_t c);
    @(negedge clk_i);
    if (idle_en && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    {p3_i, p2_i, p1_i, p0_i} <= p;
    {c3_i, c2_i, c1_i, c0_i} <= c;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic mat_t random_mat(input int hi);
    return mat($urandom_range(0, hi), $urandom_range(0, hi),
               $urandom_range(0, hi), $urandom_range(0, hi));
  endfunction

  function automatic mat_t random_invertible_mat();
    mat_t m;
    mat_t unused;
    do m = random_mat(SymMod - 1); while (!invert_mod26(m, unused));
    return m;
  endfunction

  // A known pair built from a random invertible key, then decrypts under it.
  task automatic run_key_session(input int n_decrypts);
    mat_t key;
    mat_t plain;
    key = random_invertible_mat();
    plain = random_invertible_mat();
    send_item(FuncRecover, plain, mul_mod26(key, plain));
    repeat (n_decrypts) send_item(FuncDecrypt, random_mat(31), random_mat(31));
  endtask

  task automatic mixed_traffic(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(99) < 80) begin
        run_key_session($urandom_range(0, 6));
      end else begin
        send_item(1'($urandom_range(0, 1)), random_mat(31), random_mat(31));
      end
    end
  endtask

  task automatic test_directed_cases();
    send_item(FuncDecrypt, mat(0, 0, 0, 0), mat(25, 31, 0, 0));
    send_item(FuncRecover, mat(1, 0, 0, 1), mat(3, 3, 2, 5));
    send_item(FuncDecrypt, mat(0, 0, 0, 0), mat(0, 0, 0, 0));
    send_item(FuncDecrypt, mat(0, 0, 0, 0), mat(25, 25, 0, 0));
    send_item(FuncDecrypt, mat(0, 0, 0, 0), mat(31, 26, 0, 0));
    send_item(FuncRecover, mat(0, 0, 0, 0), mat(3, 3, 2, 5));
    send_item(FuncDecrypt, mat(0, 0, 0, 0), mat(7, 9, 0, 0));
    send_item(FuncRecover, mat(2, 4, 1, 2), mat(1, 0, 0, 1));
    send_item(FuncRecover, mat(2, 0, 0, 1), mat(1, 0, 0, 1));
    send_item(FuncRecover, mat(13, 0, 0, 1), mat(1, 0, 0, 1));
    send_item(FuncRecover, mat(1, 0, 0, 1), mat(2, 0, 0, 1));
    send_item(FuncDecrypt, mat(0, 0, 0, 0), mat(11, 13, 0, 0));
    send_item(FuncRecover, mat(27, 26, 26, 27), mat(31, 26, 30, 29));
    send_item(FuncDecrypt, mat(0, 0, 0, 0), mat(31, 31, 0, 0));
    send_item(FuncRecover, mat(25, 25, 25, 25), mat(1, 0, 0, 1));
    send_item(FuncRecover, mat(31, 31, 31, 31), mat(1, 0, 0, 1));
    send_item(FuncRecover, mat(3, 2, 5, 7), mat(31, 31, 31, 31));
    send_item(FuncRecover, mat(1, 2, 3, 4), mat(1, 0, 0, 1));
    send_item(FuncRecover, mat(1, 3, 2, 1), mat(0, 25, 25, 0));
    send_item(FuncDecrypt, mat(0, 0, 0, 0), mat(1, 2, 0, 0));
    send_item(FuncDecrypt, mat(31, 31, 31, 31), mat(25, 0, 31, 31));
  endtask

  task automatic test_random_traffic();
    idle_en = 1'b1;
    mixed_traffic(600);
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    mixed_traffic(300);
    idle_en = 1'b1;
  endtask

  task automatic test_paused_sender();
    int start;
    start = items_sent;
    while (items_sent - start < 380) begin
      run_key_session($urandom_range(1, 8));
      wait_for_results();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FuncRecover;
    {p3_i, p2_i, p1_i, p0_i} = '0;
    {c3_i, c2_i, c1_i, c0_i} = '0;
    inv_key = '0;
    key_ok = 1'b0;
    errors = 0;
    items_sent = 0;
    quiet_cycles = 0;
    idle_en = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_traffic();
    test_steady_stream();
    test_paused_sender();

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
